### sv/cmbs_pkg.sv
// ----------------------------------------------------------------------------
// cmbs_pkg
// Shared types and constants of the comment and blank-line stripper.
// ----------------------------------------------------------------------------
package cmbs_pkg;

  // Character codes that the scanner looks for.
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_flag;
  } in_word_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_of_run;
    logic       ws_overflow;
  } out_word_t;

  // What one accepted word asks the emitter to send, in this order:
  // buffered whitespace, a held slash, then one tail byte.
  typedef struct packed {
    logic       flush;
    logic       slash;
    logic       tail;
    logic [7:0] tail_byte;
    logic       ovf;
  } plan_t;

  typedef enum logic [4:0] {
    MODE_NORMAL = 5'b00001,
    MODE_SLASH  = 5'b00010,
    MODE_LINE   = 5'b00100,
    MODE_BLOCK  = 5'b01000,
    MODE_STAR   = 5'b10000
  } scan_mode_e;

endpackage

### sv/cmbs_ws_ram.sv
// ----------------------------------------------------------------------------
// cmbs_ws_ram
// Leading whitespace store: one write port, one registered read port.
// ----------------------------------------------------------------------------
module cmbs_ws_ram #(
  parameter int DEPTH = 32,
  parameter int AW    = 5
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [7:0]    wdata_i,
  input  logic [AW-1:0] raddr_i,
  output logic [7:0]    rdata_o
);

  logic [7:0] mem [DEPTH];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### sv/cmbs_scanner.sv
// ----------------------------------------------------------------------------
// cmbs_scanner
// Comment scanner and blank-line filter: keeps the line state and works out
// which bytes an incoming word releases.
// ----------------------------------------------------------------------------
module cmbs_scanner
  import cmbs_pkg::*;
#(
  parameter int WS_DEPTH = 32,
  parameter int AW       = 5,
  parameter int CW       = 6
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          fire_i,
  input  in_word_t      in_data_i,
  output plan_t         plan_o,
  output logic [CW-1:0] flush_n_o,
  output logic          ws_we_o,
  output logic [AW-1:0] ws_waddr_o,
  output logic [7:0]    ws_wdata_o
);

  scan_mode_e    mode_q, mode_d;
  logic          vis_q, vis_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          ovf_q, ovf_d;

  logic [7:0] b;
  logic       is_nl, is_sp;
  logic       stage_en, stage_vis;
  logic       we;

  assign b     = in_data_i.in_byte;
  assign is_nl = (b == CH_NL);
  assign is_sp = (b == CH_SPACE) || (b == CH_TAB) || (b == CH_CR);

  always_comb begin
    mode_d    = mode_q;
    vis_d     = vis_q;
    cnt_d     = cnt_q;
    ovf_d     = ovf_q;
    plan_o    = '0;
    plan_o.ovf = ovf_q;
    stage_en  = 1'b0;
    stage_vis = vis_q;
    we        = 1'b0;

    if (in_data_i.end_flag) begin
      if (mode_q == MODE_SLASH) begin
        // The held slash is visible, so the line gets its newline too.
        plan_o.slash     = 1'b1;
        plan_o.flush     = !vis_q;
        plan_o.tail      = 1'b1;
        plan_o.tail_byte = CH_NL;
      end else if (vis_q) begin
        plan_o.tail      = 1'b1;
        plan_o.tail_byte = CH_NL;
      end
      mode_d = MODE_NORMAL;
      vis_d  = 1'b0;
      cnt_d  = '0;
      ovf_d  = 1'b0;
    end else begin
      unique case (mode_q)
        MODE_SLASH: begin
          if (b == CH_SLASH) begin
            mode_d = MODE_LINE;
          end else if (b == CH_STAR) begin
            mode_d = MODE_BLOCK;
          end else begin
            mode_d       = MODE_NORMAL;
            plan_o.slash = 1'b1;
            plan_o.flush = !vis_q;
            vis_d        = 1'b1;
            cnt_d        = '0;
            stage_en     = 1'b1;
            stage_vis    = 1'b1;
          end
        end
        MODE_LINE: begin
          if (is_nl) begin
            mode_d   = MODE_NORMAL;
            stage_en = 1'b1;
          end
        end
        MODE_BLOCK: begin
          if (b == CH_STAR) begin
            mode_d = MODE_STAR;
          end
        end
        MODE_STAR: begin
          if (b == CH_SLASH) begin
            mode_d = MODE_NORMAL;
          end else if (b != CH_STAR) begin
            mode_d = MODE_BLOCK;
          end
        end
        default: begin
          if (b == CH_SLASH) begin
            mode_d = MODE_SLASH;
          end else begin
            mode_d   = MODE_NORMAL;
            stage_en = 1'b1;
          end
        end
      endcase

      if (stage_en) begin
        if (is_nl) begin
          plan_o.tail      = stage_vis;
          plan_o.tail_byte = CH_NL;
          vis_d            = 1'b0;
          cnt_d            = '0;
          ovf_d            = 1'b0;
        end else if (stage_vis) begin
          plan_o.tail      = 1'b1;
          plan_o.tail_byte = b;
        end else if (is_sp) begin
          if (cnt_q < CW'(WS_DEPTH)) begin
            we    = 1'b1;
            cnt_d = cnt_q + 1'b1;
          end else begin
            ovf_d = 1'b1;
          end
        end else begin
          plan_o.flush     = 1'b1;
          plan_o.tail      = 1'b1;
          plan_o.tail_byte = b;
          vis_d            = 1'b1;
          cnt_d            = '0;
        end
      end
    end
  end

  assign flush_n_o  = plan_o.flush ? cnt_q : '0;
  assign ws_we_o    = fire_i && we;
  assign ws_waddr_o = cnt_q[AW-1:0];
  assign ws_wdata_o = b;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_NORMAL;
      vis_q  <= 1'b0;
      cnt_q  <= '0;
      ovf_q  <= 1'b0;
    end else if (fire_i) begin
      mode_q <= mode_d;
      vis_q  <= vis_d;
      cnt_q  <= cnt_d;
      ovf_q  <= ovf_d;
    end
  end

  // A buffer write always lands inside the store.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ws_we_o |-> (cnt_q < CW'(WS_DEPTH)))
    else $error("whitespace write beyond buffer depth");

  // Buffered whitespace only exists while the line has shown nothing visible.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    vis_q |-> (cnt_q == '0))
    else $error("whitespace still buffered on a visible line");

  // Overflow is flagged only once the buffer is full.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire_i && !ovf_q && ovf_d) |-> (cnt_q == CW'(WS_DEPTH)))
    else $error("overflow flagged with buffer space left");

endmodule

### sv/comment_and_blank_line_stripper_core.sv
// ----------------------------------------------------------------------------
// comment_and_blank_line_stripper_core
// Strips C comments and blank lines from a byte stream.
//
//   channel | direction | handshake             | word
//   --------+-----------+-----------------------+----------------------------
//   in      | input     | in_valid_i/in_stall_o | in_byte, end_flag
//   out     | output    | out_valid_o/out_stall_i | out_byte, last_of_run,
//           |           |                       | ws_overflow
//
// A word that yields at most one output byte without a held slash goes
// straight to the output register: plain text flows at one word per cycle
// unless the output stalls. A word that releases buffered whitespace sends
// each whitespace byte, read from the registered whitespace RAM, then a held
// slash, then a tail byte; input is stalled meanwhile. Reset is asynchronous
// and clears the control state; the whitespace RAM is not cleared. Output
// stall holds the output register and, through it, the input.
// ----------------------------------------------------------------------------
module comment_and_blank_line_stripper_core
  import cmbs_pkg::*;
#(
  parameter int WS_DEPTH = 32
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_word_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_word_t out_data_o
);

  localparam int AW = (WS_DEPTH > 1) ? $clog2(WS_DEPTH) : 1;
  localparam int CW = $clog2(WS_DEPTH + 1);

  typedef enum logic [3:0] {
    ST_IDLE     = 4'b0001,
    ST_FLUSH_RD = 4'b0010,
    ST_FLUSH_WR = 4'b0100,
    ST_TAIL     = 4'b1000
  } seq_state_e;

  seq_state_e    state_q, state_d;
  plan_t         plan, plan_q, plan_d;
  logic [CW-1:0] flush_n, n_q, n_d, idx_q, idx_d, idx_nxt;
  logic          ws_we;
  logic [AW-1:0] ws_waddr;
  logic [7:0]    ws_wdata, ws_rdata;

  logic      in_fire, out_free, out_load;
  out_word_t out_q, out_d;
  logic      out_valid_q, last_flush;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != ST_IDLE) || !out_free;
  assign in_fire    = in_valid_i && !in_stall_o;

  cmbs_scanner #(
    .WS_DEPTH (WS_DEPTH),
    .AW       (AW),
    .CW       (CW)
  ) u_scanner (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .fire_i     (in_fire),
    .in_data_i  (in_data_i),
    .plan_o     (plan),
    .flush_n_o  (flush_n),
    .ws_we_o    (ws_we),
    .ws_waddr_o (ws_waddr),
    .ws_wdata_o (ws_wdata)
  );

  // Writes happen only on accepted words and reads only while flushing, so
  // the input stall keeps the two apart.
  cmbs_ws_ram #(
    .DEPTH (WS_DEPTH),
    .AW    (AW)
  ) u_ws_ram (
    .clk_i   (clk_i),
    .we_i    (ws_we),
    .waddr_i (ws_waddr),
    .wdata_i (ws_wdata),
    .raddr_i (idx_q[AW-1:0]),
    .rdata_o (ws_rdata)
  );

  assign idx_nxt    = idx_q + 1'b1;
  assign last_flush = (idx_nxt == n_q) && !plan_q.slash && !plan_q.tail;

  always_comb begin
    state_d  = state_q;
    plan_d   = plan_q;
    n_d      = n_q;
    idx_d    = idx_q;
    out_load = 1'b0;
    out_d    = out_q;

    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          if (!plan.slash && (flush_n == '0)) begin
            if (plan.tail) begin
              out_load = 1'b1;
              out_d    = '{out_byte: plan.tail_byte, last_of_run: 1'b1,
                           ws_overflow: plan.ovf};
            end
          end else begin
            plan_d  = plan;
            n_d     = flush_n;
            idx_d   = '0;
            state_d = (flush_n != '0) ? ST_FLUSH_RD : ST_TAIL;
          end
        end
      end
      ST_FLUSH_RD: begin
        state_d = ST_FLUSH_WR;
      end
      ST_FLUSH_WR: begin
        if (out_free) begin
          out_load = 1'b1;
          out_d    = '{out_byte: ws_rdata, last_of_run: last_flush,
                       ws_overflow: plan_q.ovf};
          idx_d    = idx_nxt;
          if (idx_nxt == n_q) begin
            state_d = last_flush ? ST_IDLE : ST_TAIL;
          end else begin
            state_d = ST_FLUSH_RD;
          end
        end
      end
      ST_TAIL: begin
        if (out_free) begin
          out_load = 1'b1;
          if (plan_q.slash) begin
            out_d        = '{out_byte: CH_SLASH, last_of_run: !plan_q.tail,
                             ws_overflow: plan_q.ovf};
            plan_d.slash = 1'b0;
            if (!plan_q.tail) begin
              state_d = ST_IDLE;
            end
          end else begin
            out_d   = '{out_byte: plan_q.tail_byte, last_of_run: 1'b1,
                        ws_overflow: plan_q.ovf};
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      idx_q       <= '0;
      n_q         <= '0;
      plan_q      <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      n_q     <= n_d;
      plan_q  <= plan_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // New words are taken only when the emitter has nothing left to send.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |-> (state_q == ST_IDLE))
    else $error("word accepted while emitting");

  // The flush index never runs past the number of buffered bytes.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_FLUSH_RD) || (state_q == ST_FLUSH_WR)) |-> (idx_q < n_q))
    else $error("flush index out of range");

  // The tail phase always has something to send.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_TAIL) |-> (plan_q.slash || plan_q.tail))
    else $error("tail phase with nothing pending");

  // A byte that is not the last of its run leaves the emitter busy.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && !out_d.last_of_run) |=> (state_q != ST_IDLE))
    else $error("run ended without its last byte");

endmodule
